// ===== rtl/gdsl_pkg.sv =====
// Shared types and codes for the grouped distance-sorted list engine.
package gdsl_pkg;

	// Request kinds carried in the input beat.
	localparam logic [1:0] REQ_SORTED = 2'd0;
	localparam logic [1:0] REQ_ACTIVE = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_GROUP_FULL = 2'd1;
	localparam logic [1:0] ST_POOL_FULL  = 2'd2;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_GSCAN,
		S_GWAIT,
		S_DECIDE,
		S_SHEAD,
		S_SWALK,
		S_SWAIT,
		S_AHEAD,
		S_AWALK,
		S_AKEY,
		S_AWAIT,
		S_COMMIT,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input beat
		logic clear;    // empty table and pools
		logic gscan;    // issue group key read and advance index
		logic gcreate;  // create group at group_total
		logic shead;    // load sorted walk pointer from the group head
		logic ahead;    // load active walk pointer from the group head
		logic wread;    // read the node under the walk pointer
		logic akey;     // read the key of the active successor
		logic sstep;    // advance the sorted walk by one node
		logic astep;    // advance the active walk by one node
		logic commit;   // write node and links
		logic finish;   // form result and present it
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic is_sorted;
		logic is_unused;
		logic gscan_done;  // index reached group_total
		logic gmatch;      // last read key matched
		logic gfull;
		logic sfull;
		logic afull;
		logic walk_stop;   // walk reached its end
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/gdsl_ctrl.sv =====
// Controller state machine sequencing group search and list walks.
module gdsl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  gdsl_pkg::stat_t  st,
	output gdsl_pkg::cmd_t   cmd,
	output logic             in_ready
);
	import gdsl_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_GSCAN;
			end
			S_GSCAN: begin
				if (st.is_clear || st.is_unused) state_d = S_OUT;
				else if (st.gscan_done) state_d = S_DECIDE;
				else state_d = S_GWAIT;
			end
			S_GWAIT: begin
				if (st.gmatch) state_d = S_DECIDE;
				else state_d = S_GSCAN;
			end
			S_DECIDE: begin
				if (!st.gmatch && st.gfull) state_d = S_OUT;
				else if (st.is_sorted) state_d = st.sfull ? S_OUT : S_SHEAD;
				else state_d = st.afull ? S_OUT : S_AHEAD;
			end
			S_SHEAD: state_d = S_SWALK;
			S_SWALK: state_d = S_SWAIT;
			S_SWAIT: begin
				if (st.walk_stop) state_d = S_COMMIT;
				else state_d = S_SWALK;
			end
			S_AHEAD: state_d = S_AWALK;
			S_AWALK: state_d = S_AKEY;
			S_AKEY: state_d = S_AWAIT;
			S_AWAIT: begin
				if (st.walk_stop) state_d = S_COMMIT;
				else state_d = S_AWALK;
			end
			S_COMMIT: state_d = S_OUT;
			S_OUT: begin
				if (!st.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			S_GSCAN: begin
				cmd.clear = st.is_clear;
				cmd.gscan = !(st.is_clear || st.is_unused) && !st.gscan_done;
			end
			S_DECIDE: cmd.gcreate = !st.gmatch && !st.gfull;
			S_SHEAD: cmd.shead = 1'b1;
			S_SWALK: cmd.wread = 1'b1;
			S_SWAIT: cmd.sstep = !st.walk_stop;
			S_AHEAD: cmd.ahead = 1'b1;
			S_AWALK: cmd.wread = 1'b1;
			S_AKEY: cmd.akey = 1'b1;
			S_AWAIT: cmd.astep = !st.walk_stop;
			S_COMMIT: cmd.commit = 1'b1;
			S_OUT: cmd.finish = !st.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/gdsl_dpath.sv =====
// Datapath: group table, node pools, list walk registers and result register.
module gdsl_dpath #(
	parameter int MAX_GROUPS = 64,
	parameter int MAX_ACTIVE = 64,
	parameter int MAX_SORTED = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gdsl_pkg::cmd_t  cmd,
	output gdsl_pkg::stat_t st,
	input  logic [1:0]      req_type,
	input  logic [31:0]     group_key,
	input  logic [31:0]     emitter_id,
	input  logic [31:0]     distance,
	input  logic [31:0]     payload_a,
	input  logic [31:0]     payload_b,
	input  logic [31:0]     payload_c,
	input  logic [31:0]     payload_d,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      o_status,
	output logic [5:0]      o_group_slot,
	output logic            o_group_created,
	output logic [5:0]      o_node_slot,
	output logic [6:0]      o_list_position
);
	import gdsl_pkg::*;

	localparam int GW = $clog2(MAX_GROUPS);
	localparam int AW = $clog2(MAX_ACTIVE);
	localparam int SW = $clog2(MAX_SORTED);
	localparam int PW = $clog2(MAX_SORTED + MAX_ACTIVE + 2);

	// Memories.
	logic [31:0]  gkey_mem [MAX_GROUPS];
	logic [AW:0]  ahead_mem [MAX_GROUPS];
	logic [SW:0]  shead_mem [MAX_GROUPS];
	logic [AW:0]  alink_mem [MAX_ACTIVE];
	logic [31:0]  akey_mem [MAX_ACTIVE];
	logic [127:0] adata_mem [MAX_ACTIVE];
	logic [31:0]  aref_mem [MAX_ACTIVE];
	logic [SW:0]  slink_mem [MAX_SORTED];
	logic [31:0]  skey_mem [MAX_SORTED];
	logic [31:0]  sref_mem [MAX_SORTED];

	// Captured request.
	logic [1:0]   req_q;
	logic [31:0]  key_q, emit_q, dist_q;
	logic [127:0] pay_q;

	// Counters and walk registers.
	logic [GW:0]  gtotal_q, gidx_q;
	logic [AW:0]  aused_q;
	logic [SW:0]  sused_q;
	logic [GW-1:0] gslot_q;
	logic         gmatch_q, created_q;
	logic [31:0]  gkey_rd_q;
	logic         grd_pend_q;
	logic [SW:0]  sprev_q, snode_q;
	logic [AW:0]  ascan_q, anext_q;
	logic [31:0]  nkey_q;
	logic [SW:0]  slink_rd_q;
	logic [PW-1:0] pos_q;
	logic         node_done_q;  // node written for this request

	// Result register.
	logic [1:0] rs_q;
	logic [5:0] rg_q, rn_q;
	logic       rc_q;
	logic [6:0] rp_q;

	logic key_hit;
	assign key_hit = (gkey_rd_q == key_q) && grd_pend_q;

	// Walk termination decided from the node registers read in earlier cycles.
	logic s_stop, a_stop;
	assign s_stop = !((snode_q < (SW+1)'(MAX_SORTED)) && (nkey_q <= dist_q));
	assign a_stop = (ascan_q >= (AW+1)'(MAX_ACTIVE)) || (anext_q >= (AW+1)'(MAX_ACTIVE))
		|| (nkey_q < dist_q);

	// Status.
	always_comb begin
		st = '0;
		st.is_clear   = (req_q == REQ_CLEAR);
		st.is_sorted  = (req_q == REQ_SORTED);
		st.is_unused  = (req_q == REQ_UNUSED);
		st.gscan_done = (gidx_q >= gtotal_q);
		st.gmatch     = gmatch_q || key_hit;
		st.gfull      = (gtotal_q >= (GW+1)'(MAX_GROUPS));
		st.sfull      = (sused_q >= (SW+1)'(MAX_SORTED));
		st.afull      = (aused_q >= (AW+1)'(MAX_ACTIVE));
		st.walk_stop  = (req_q == REQ_SORTED) ? s_stop : a_stop;
		st.out_busy   = out_valid && !out_ready;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gtotal_q    <= '0;
			aused_q     <= '0;
			sused_q     <= '0;
			out_valid   <= 1'b0;
			grd_pend_q  <= 1'b0;
			gmatch_q    <= 1'b0;
			created_q   <= 1'b0;
			node_done_q <= 1'b0;
			gidx_q      <= '0;
		end else begin
			// Result valid rises on finish and falls when the beat is taken.
			if (cmd.finish) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.load) begin
				gidx_q <= '0;
				gmatch_q <= 1'b0;
				created_q <= 1'b0;
				grd_pend_q <= 1'b0;
				node_done_q <= 1'b0;
			end
			if (cmd.gscan) begin
				gidx_q <= gidx_q + 1'b1;
				grd_pend_q <= 1'b1;
			end else if (grd_pend_q) begin
				grd_pend_q <= 1'b0;
				if (key_hit) gmatch_q <= 1'b1;
			end
			if (cmd.clear) begin
				gtotal_q <= '0;
				aused_q  <= '0;
				sused_q  <= '0;
			end
			if (cmd.gcreate) begin
				gtotal_q  <= gtotal_q + 1'b1;
				created_q <= 1'b1;
			end
			if (cmd.commit) begin
				node_done_q <= 1'b1;
				if (req_q == REQ_SORTED) sused_q <= sused_q + 1'b1;
				else aused_q <= aused_q + 1'b1;
			end
		end
	end

	// Payload and walk data registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			key_q  <= group_key;
			emit_q <= emitter_id;
			dist_q <= distance;
			pay_q  <= {payload_d, payload_c, payload_b, payload_a};
		end
		if (cmd.gscan) begin
			gkey_rd_q <= gkey_mem[gidx_q[GW-1:0]];
			gslot_q   <= gidx_q[GW-1:0];
		end
		if (cmd.gcreate) begin
			gslot_q <= gtotal_q[GW-1:0];
			gkey_mem[gtotal_q[GW-1:0]]  <= key_q;
			ahead_mem[gtotal_q[GW-1:0]] <= (AW+1)'(MAX_ACTIVE);
			shead_mem[gtotal_q[GW-1:0]] <= (SW+1)'(MAX_SORTED);
		end
		// Sorted walk: snode_q is the candidate, sprev_q the node before it.
		if (cmd.shead) begin
			sprev_q <= (SW+1)'(MAX_SORTED);
			snode_q <= shead_mem[gslot_q];
			pos_q   <= '0;
		end
		if (cmd.sstep) begin
			sprev_q <= snode_q;
			snode_q <= slink_rd_q;
			pos_q   <= pos_q + 1'b1;
		end
		// Active walk: ascan_q current, anext_q its successor. An empty list
		// puts the new node at the head.
		if (cmd.ahead) begin
			ascan_q <= ahead_mem[gslot_q];
			pos_q   <= (ahead_mem[gslot_q] >= (AW+1)'(MAX_ACTIVE)) ? '0 : PW'(1);
		end
		if (cmd.astep) begin
			ascan_q <= anext_q;
			pos_q   <= pos_q + 1'b1;
		end
		// Node read under the walk pointer.
		if (cmd.wread) begin
			if (req_q == REQ_SORTED) begin
				if (snode_q < (SW+1)'(MAX_SORTED)) begin
					nkey_q     <= skey_mem[snode_q[SW-1:0]];
					slink_rd_q <= slink_mem[snode_q[SW-1:0]];
				end
			end else if (ascan_q < (AW+1)'(MAX_ACTIVE)) begin
				anext_q <= alink_mem[ascan_q[AW-1:0]];
			end
		end
		// Key of the active successor.
		if (cmd.akey && anext_q < (AW+1)'(MAX_ACTIVE))
			nkey_q <= akey_mem[anext_q[AW-1:0]];
		if (cmd.commit) begin
			if (req_q == REQ_SORTED) begin
				if (sprev_q >= (SW+1)'(MAX_SORTED)) shead_mem[gslot_q] <= sused_q;
				else slink_mem[sprev_q[SW-1:0]] <= sused_q;
				slink_mem[sused_q[SW-1:0]] <= snode_q;
				skey_mem[sused_q[SW-1:0]]  <= dist_q;
				sref_mem[sused_q[SW-1:0]]  <= emit_q;
			end else begin
				if (ascan_q >= (AW+1)'(MAX_ACTIVE)) begin
					ahead_mem[gslot_q] <= aused_q;
					alink_mem[aused_q[AW-1:0]] <= (AW+1)'(MAX_ACTIVE);
				end else begin
					alink_mem[aused_q[AW-1:0]] <= anext_q;
					alink_mem[ascan_q[AW-1:0]] <= aused_q;
				end
				akey_mem[aused_q[AW-1:0]]  <= dist_q;
				adata_mem[aused_q[AW-1:0]] <= pay_q;
				aref_mem[aused_q[AW-1:0]]  <= emit_q;
			end
		end
		// Result fields for the finished request.
		if (cmd.finish) begin
			if (req_q != REQ_SORTED && req_q != REQ_ACTIVE) begin
				rs_q <= ST_DONE;
				rg_q <= '0;
				rc_q <= 1'b0;
				rn_q <= '0;
				rp_q <= '0;
			end else if (!gmatch_q && !created_q) begin
				rs_q <= ST_GROUP_FULL;
				rg_q <= '0;
				rc_q <= 1'b0;
				rn_q <= '0;
				rp_q <= '0;
			end else if (!node_done_q) begin
				rs_q <= ST_POOL_FULL;
				rg_q <= 6'(gslot_q);
				rc_q <= created_q;
				rn_q <= '0;
				rp_q <= '0;
			end else begin
				rs_q <= ST_DONE;
				rg_q <= 6'(gslot_q);
				rc_q <= created_q;
				rn_q <= (req_q == REQ_SORTED) ? 6'(sused_q - 1'b1)
					: 6'(aused_q - 1'b1);
				rp_q <= 7'(pos_q);
			end
		end
	end

	assign o_status        = rs_q;
	assign o_group_slot    = rg_q;
	assign o_group_created = rc_q;
	assign o_node_slot     = rn_q;
	assign o_list_position = rp_q;

endmodule

// ===== rtl/grouped_distance_sorted_lists.sv =====
// Top level of the grouped distance-sorted list engine.
// One request is in work at a time. The key search compares the stored groups
// one at a time; a sorted insert then passes one list node per step of read
// and wait, an active insert one per step of read, successor key read and
// wait. The worst case is a key found in the last of 64 groups followed by an
// active walk over 63 nodes, set by the single-port key table scan and the
// one-node-per-step list walk. A clear request goes from the scan straight to
// the result. A new request is accepted while the previous result still waits,
// and its own result then waits until that beat has been taken.
module grouped_distance_sorted_lists #(
	parameter int MAX_GROUPS = 64,
	parameter int MAX_ACTIVE = 64,
	parameter int MAX_SORTED = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[1:0], group_key[33:2], emitter_id[65:34], distance[97:66],
	// payload_a[129:98], payload_b[161:130], payload_c[193:162],
	// payload_d[225:194], zero fill to 232
	input  logic [231:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], group_slot[7:2], group_created[8], node_slot[14:9],
	// list_position[21:15], zero fill to 24
	output logic [23:0]  m_tdata
);
	import gdsl_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  in_fire;
	logic [1:0] o_st;
	logic [5:0] o_gs, o_ns;
	logic       o_gc;
	logic [6:0] o_lp;

	assign in_fire = s_tvalid && s_tready;

	gdsl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .st(st),
		.cmd(cmd), .in_ready(s_tready)
	);

	gdsl_dpath #(
		.MAX_GROUPS(MAX_GROUPS), .MAX_ACTIVE(MAX_ACTIVE), .MAX_SORTED(MAX_SORTED)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.req_type(s_tdata[1:0]), .group_key(s_tdata[33:2]),
		.emitter_id(s_tdata[65:34]), .distance(s_tdata[97:66]),
		.payload_a(s_tdata[129:98]), .payload_b(s_tdata[161:130]),
		.payload_c(s_tdata[193:162]), .payload_d(s_tdata[225:194]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.o_status(o_st), .o_group_slot(o_gs), .o_group_created(o_gc),
		.o_node_slot(o_ns), .o_list_position(o_lp)
	);

	assign m_tdata = {2'b00, o_lp, o_ns, o_gc, o_gs, o_st};

endmodule
